// ----- rtl/weighted_common_substring_defines.svh -----
// assertion macros for the weighted common substring block
// used by the port checker; expects clk and rst_n in scope
`ifndef WEIGHTED_COMMON_SUBSTRING_DEFINES_SVH
`define WEIGHTED_COMMON_SUBSTRING_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define WCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wcs_pkg.sv -----
// shared types, widths and codes for the weighted common substring block
// no dependencies
`timescale 1ns / 1ps

package wcs_pkg;

  localparam int S_LEN    = 64;
  localparam int S_IDX_W  = $clog2(S_LEN);
  localparam int S_CNT_W  = $clog2(S_LEN + 1);
  localparam int ALPHABET = 26;
  localparam int SYM_W    = 5;
  localparam int WEIGHT_W = 15;
  localparam int PEN_W    = 16;
  localparam int SCORE_W  = 32;
  localparam int RUN_W    = 7;
  localparam int TPOS_W   = 16;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [TPOS_W-1:0] TPOS_MAX = '1;

  // request codes
  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_STREAM = 2'd2;

  // register select (word address bit)
  localparam logic REG_PENALTY = 1'b0;
  localparam logic REG_FLOOR   = 1'b1;

  localparam logic [PEN_W-1:0]   PENALTY_RST = 16'hF600;
  localparam logic [SCORE_W-1:0] FLOOR_RST   = 32'h8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINAL
  } wcs_state_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SYM_W-1:0]    symbol;
    logic [WEIGHT_W-1:0] weight_value;
    logic                is_last;
  } wcs_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] top_score;
    logic [S_IDX_W-1:0]        s_start;
    logic [TPOS_W-1:0]         t_start;
    logic [RUN_W-1:0]          match_length;
    logic                      found;
  } wcs_out_t;

  // score and run of one cell
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [RUN_W-1:0]          run;
  } wcs_scan_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic [SYM_W-1:0]        sym;
    logic [WEIGHT_W-1:0]     weight;
    logic signed [PEN_W-1:0] penalty;
    logic                    first_col;
    logic                    update;
    logic                    shift;
    logic                    clear;
  } wcs_bcast_t;

  // controls for the best tracker
  typedef struct packed {
    logic                      step;
    logic                      clear;
    logic [S_IDX_W-1:0]        row;
    logic [TPOS_W-1:0]         col;
    logic signed [SCORE_W-1:0] floor;
  } wcs_best_ctrl_t;

endpackage

// ----- rtl/weighted_common_substring.sv -----
// Top level: a T letter beat updates every cell of the column when it is
// accepted, then one row a cycle passes the head compare. A final T letter
// then loads the result register, once the result register is free. Weight
// and S letter beats start no scan. Inputs are taken while a result waits,
// unless the next final result is also ready. Synchronous active-low reset
// clears the job, weights and registers.
`timescale 1ns / 1ps

module weighted_common_substring (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wcs_pkg::wcs_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wcs_pkg::wcs_out_t               out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [wcs_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [wcs_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [wcs_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                            cfg_pready
);
  import wcs_pkg::*;

  wcs_state_t state_r, state_nxt;

  logic signed [PEN_W-1:0]   penalty_r;
  logic signed [SCORE_W-1:0] floor_r;
  logic [WEIGHT_W-1:0]       weight_r [ALPHABET];
  logic [S_CNT_W-1:0]        s_count_r;
  logic [TPOS_W-1:0]         t_pos_r;
  logic [TPOS_W-1:0]         col_r;
  logic                      last_r;
  logic [S_IDX_W-1:0]        scan_cnt_r;
  logic                      out_valid_r;
  wcs_out_t                  out_data_r;

  logic in_acc, stream_acc, append_ok, weight_wr, cfg_wr;
  logic sym_ok, scan_done, final_load, shift_en;
  logic [WEIGHT_W-1:0] t_weight;

  wcs_bcast_t     bc;
  wcs_best_ctrl_t best_ctrl;
  wcs_scan_t      col_w  [S_LEN];
  wcs_scan_t      scan_w [S_LEN];

  logic                      have_best;
  logic signed [SCORE_W-1:0] best_value;
  logic [S_IDX_W-1:0]        best_row;
  logic [TPOS_W-1:0]         best_col;
  logic [RUN_W-1:0]          best_run;

  // beat decode
  assign in_acc     = in_valid && !in_stall;
  assign stream_acc = in_acc && (in_data.req_type == REQ_STREAM);
  assign sym_ok     = in_data.symbol < SYM_W'(ALPHABET);
  assign weight_wr  = in_acc && (in_data.req_type == REQ_WEIGHT) && sym_ok;
  assign append_ok  = in_acc && (in_data.req_type == REQ_APPEND) &&
                      (t_pos_r == '0) && (s_count_r < S_CNT_W'(S_LEN));
  assign scan_done  = ({1'b0, scan_cnt_r} == (s_count_r - S_CNT_W'(1)));
  assign t_weight   = sym_ok ? weight_r[in_data.symbol] : '0;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_FLOOR) ? floor_r : DATA_W'(penalty_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      penalty_r <= PENALTY_RST;
      floor_r   <= FLOOR_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_PENALTY: penalty_r <= cfg_pwdata[PEN_W-1:0];
        REG_FLOOR:   floor_r   <= cfg_pwdata[SCORE_W-1:0];
        default:     ;
      endcase
    end
  end

  // weight table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ALPHABET; k++) begin
        weight_r[k] <= '0;
      end
    end else if (weight_wr) begin
      weight_r[in_data.symbol] <= in_data.weight_value;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (stream_acc) begin
          if (s_count_r != '0) begin
            state_nxt = ST_SCAN;
          end else if (in_data.is_last) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = last_r ? ST_FINAL : ST_IDLE;
        end
      end
      ST_FINAL: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall   = 1'b1;
    shift_en   = 1'b0;
    final_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_SCAN:  shift_en = 1'b1;
      ST_FINAL: final_load = !out_valid_r || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // job counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_count_r  <= '0;
      t_pos_r    <= '0;
      scan_cnt_r <= '0;
    end else if (final_load) begin
      s_count_r  <= '0;
      t_pos_r    <= '0;
      scan_cnt_r <= '0;
    end else begin
      if (append_ok) begin
        s_count_r <= s_count_r + S_CNT_W'(1);
      end
      if (stream_acc) begin
        scan_cnt_r <= '0;
        if (t_pos_r != TPOS_MAX) begin
          t_pos_r <= t_pos_r + TPOS_W'(1);
        end
      end else if (shift_en) begin
        scan_cnt_r <= scan_cnt_r + S_IDX_W'(1);
      end
    end
  end

  // column index and last flag of the beat under scan
  always_ff @(posedge clk) begin
    if (stream_acc) begin
      col_r  <= t_pos_r;
      last_r <= in_data.is_last;
    end
  end

  // broadcast to the cells
  always_comb begin
    bc.sym       = in_data.symbol;
    bc.weight    = t_weight;
    bc.penalty   = penalty_r;
    bc.first_col = (t_pos_r == '0);
    bc.update    = stream_acc;
    bc.shift     = shift_en;
    bc.clear     = final_load;
  end

  // row of cells
  for (genvar i = 0; i < S_LEN; i++) begin : g_cell
    wcs_scan_t diag_w;
    wcs_scan_t next_w;
    logic      active_w;
    logic      wr_w;

    if (i == 0) begin : g_head
      assign diag_w = '0;
    end else begin : g_body
      assign diag_w = col_w[i-1];
    end
    if (i == S_LEN - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_link
      assign next_w = scan_w[i+1];
    end

    assign active_w = s_count_r > S_CNT_W'(i);
    assign wr_w     = append_ok && (s_count_r[S_IDX_W-1:0] == S_IDX_W'(i));

    wcs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bc        (bc),
      .active    (active_w),
      .wr_letter (wr_w),
      .no_diag   (i == 0),
      .diag_in   (diag_w),
      .col_out   (col_w[i]),
      .scan_in   (next_w),
      .scan_out  (scan_w[i])
    );
  end

  // best tracker at the head of the chain
  always_comb begin
    best_ctrl.step  = shift_en;
    best_ctrl.clear = final_load;
    best_ctrl.row   = scan_cnt_r;
    best_ctrl.col   = col_r;
    best_ctrl.floor = floor_r;
  end

  wcs_best u_best (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (best_ctrl),
    .cand       (scan_w[0]),
    .have_best  (have_best),
    .best_value (best_value),
    .best_row   (best_row),
    .best_col   (best_col),
    .best_run   (best_run)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (final_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (final_load) begin
      if (have_best) begin
        out_data_r.top_score    <= best_value;
        out_data_r.s_start      <= best_row + S_IDX_W'(1) - best_run[S_IDX_W-1:0];
        out_data_r.t_start      <= best_col + TPOS_W'(1) - TPOS_W'(best_run);
        out_data_r.match_length <= best_run;
        out_data_r.found        <= 1'b1;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/wcs_cell.sv -----
// one cell of the dp column: holds one S letter, its score and run,
// and a scan register that hands the column out toward cell 0; uses wcs_pkg
`timescale 1ns / 1ps

module wcs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  wcs_pkg::wcs_bcast_t bc,
  input  logic               active,
  input  logic               wr_letter,
  input  logic               no_diag,
  input  wcs_pkg::wcs_scan_t diag_in,
  output wcs_pkg::wcs_scan_t col_out,
  input  wcs_pkg::wcs_scan_t scan_in,
  output wcs_pkg::wcs_scan_t scan_out
);
  import wcs_pkg::*;

  logic [SYM_W-1:0]          letter_r;
  logic signed [SCORE_W-1:0] score_r, score_nxt;
  logic [RUN_W-1:0]          run_r, run_nxt;
  wcs_scan_t                 scan_r;

  logic signed [SCORE_W-1:0] own;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] ext;
  logic signed [SCORE_W-1:0] new_score;
  logic [RUN_W-1:0]          new_run;

  // own score of this cell for the current T letter
  always_comb begin
    if (letter_r == bc.sym) begin
      own = $signed({{(SCORE_W-WEIGHT_W){1'b0}}, bc.weight});
    end else begin
      own = SCORE_W'(bc.penalty);
    end
  end

  // saturating diagonal extension
  always_comb begin
    sum = {diag_in.score[SCORE_W-1], diag_in.score} + {own[SCORE_W-1], own};
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      ext = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      ext = sum[SCORE_W-1:0];
    end
  end

  // cell recurrence
  always_comb begin
    if (no_diag || bc.first_col) begin
      new_score = own;
      new_run   = RUN_W'(1);
    end else begin
      new_score = (ext > own) ? ext : own;
      new_run   = diag_in.score[SCORE_W-1] ? RUN_W'(1) : diag_in.run + RUN_W'(1);
    end
    score_nxt = score_r;
    run_nxt   = run_r;
    if (bc.clear) begin
      score_nxt = '0;
      run_nxt   = '0;
    end else if (bc.update && active) begin
      score_nxt = new_score;
      run_nxt   = new_run;
    end
  end

  // column state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      run_r   <= '0;
    end else begin
      score_r <= score_nxt;
      run_r   <= run_nxt;
    end
  end

  // letter store, no reset
  always_ff @(posedge clk) begin
    if (wr_letter) begin
      letter_r <= bc.sym;
    end
  end

  // scan register: load new column, then shift toward cell 0
  always_ff @(posedge clk) begin
    if (bc.update) begin
      scan_r.score <= score_nxt;
      scan_r.run   <= run_nxt;
    end else if (bc.shift) begin
      scan_r <= scan_in;
    end
  end

  assign col_out.score = score_r;
  assign col_out.run   = run_r;
  assign scan_out      = scan_r;

endmodule

// ----- rtl/wcs_best.sv -----
// best-cell tracker at the head of the cell chain, one row per cycle while step is set
// uses wcs_pkg
`timescale 1ns / 1ps

module wcs_best (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wcs_pkg::wcs_best_ctrl_t   ctrl,
  input  wcs_pkg::wcs_scan_t        cand,
  output logic                      have_best,
  output logic signed [31:0]        best_value,
  output logic [wcs_pkg::S_IDX_W-1:0] best_row,
  output logic [wcs_pkg::TPOS_W-1:0]  best_col,
  output logic [wcs_pkg::RUN_W-1:0]   best_run
);
  import wcs_pkg::*;

  logic                      have_r, have_nxt;
  logic signed [SCORE_W-1:0] value_r;
  logic [S_IDX_W-1:0]        row_r;
  logic [TPOS_W-1:0]         col_r;
  logic [RUN_W-1:0]          run_r;
  logic                      take;

  // strictly better, ties to the lower row
  always_comb begin
    if (!have_r) begin
      take = cand.score > ctrl.floor;
    end else begin
      take = (cand.score > value_r) || ((cand.score == value_r) && (ctrl.row < row_r));
    end
    have_nxt = have_r;
    if (ctrl.clear) begin
      have_nxt = 1'b0;
    end else if (ctrl.step && take) begin
      have_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  // best cell payload
  always_ff @(posedge clk) begin
    if (ctrl.step && take && !ctrl.clear) begin
      value_r <= cand.score;
      row_r   <= ctrl.row;
      col_r   <= ctrl.col;
      run_r   <= cand.run;
    end
  end

  assign have_best  = have_r;
  assign best_value = value_r;
  assign best_row   = row_r;
  assign best_col   = col_r;
  assign best_run   = run_r;

endmodule

// ----- rtl/wcs_checker.sv -----
// port checker for the weighted common substring top level, with its bind
// uses wcs_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "weighted_common_substring_defines.svh"

module wcs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input wcs_pkg::wcs_out_t out_data
);
  import wcs_pkg::*;

  logic [7:0] run_end;

  // row just past the best run
  assign run_end = 8'(out_data.s_start) + 8'(out_data.match_length);

  // a stalled result beat holds
  `WCS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // an empty result carries all-zero fields
  `WCS_ASSERT_IMP(a_empty_zero, out_valid && !out_data.found, (out_data.top_score == '0) && (out_data.s_start == '0) && (out_data.t_start == '0) && (out_data.match_length == '0), "empty result has nonzero fields")

  // a found run is nonempty and lies inside S
  `WCS_ASSERT_IMP(a_run_in_s, out_valid && out_data.found, (out_data.match_length != '0) && (run_end <= 8'(S_LEN)), "found run outside S")

endmodule

bind weighted_common_substring wcs_checker u_wcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- sim/tb_top.sv -----
// self-checking testbench for weighted_common_substring
// needs wcs_pkg and the weighted_common_substring rtl; scores every beat with its own model
`timescale 1ns / 1ps

module tb_top;
  import wcs_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEM_TARGET      = 1450;
  localparam int MAX_GAP          = 12;
  localparam int SETTLE_CYCLES    = 2 * (S_LEN + 1) + 10;
  localparam int WATCHDOG_LIMIT   = 10000;
  localparam int LONG_HOLD_AT     = 20;
  localparam int LONG_HOLD_CYCLES = 1500;
  localparam int LONG_T_LETTERS   = 120;
  localparam longint SCORE_HI     = 64'sd2147483647;
  localparam longint SCORE_LO     = -64'sd2147483648;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  wcs_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wcs_out_t            out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  weighted_common_substring u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // request beats waiting to be sent, job reports waiting to arrive
  wcs_in_t  req_q[$];
  wcs_out_t report_q[$];
  wcs_out_t want;

  int n_items;
  int n_reports;
  int n_bad;
  int send_gap;
  int recv_hold;
  int idle_cycles;
  bit quiet;

  // scoring model state
  logic signed [PEN_W-1:0]   mism_pen;
  logic signed [SCORE_W-1:0] min_score;
  logic [WEIGHT_W-1:0]       letter_wt [ALPHABET];
  logic [SYM_W-1:0]          s_sym [S_LEN];
  int unsigned               s_cnt;
  logic signed [SCORE_W-1:0] col_sc [S_LEN];
  int unsigned               col_rn [S_LEN];
  int unsigned               t_pos;
  logic signed [SCORE_W-1:0] best_val;
  int unsigned               best_r;
  int unsigned               best_c;
  int unsigned               best_rn;
  bit                        have_best;

  // forget S, the column and the best cell; weights and registers stay
  function automatic void drop_job();
    for (int i = 0; i < S_LEN; i++) begin
      s_sym[i]  = '0;
      col_sc[i] = '0;
      col_rn[i] = 0;
    end
    s_cnt     = 0;
    t_pos     = 0;
    best_val  = min_score;
    best_r    = 0;
    best_c    = 0;
    best_rn   = 0;
    have_best = 1'b0;
  endfunction

  // apply one accepted request beat, queue the report of a final T letter
  function automatic void score_request(wcs_in_t it);
    logic signed [SCORE_W-1:0] new_sc [S_LEN];
    int unsigned               new_rn [S_LEN];
    logic signed [SCORE_W-1:0] own, diag, ext, v;
    longint                    sum;
    bit                        take;
    int unsigned               col;
    wcs_out_t                  rpt;
    case (it.req_type)
      REQ_WEIGHT: begin
        if (it.symbol < ALPHABET) letter_wt[it.symbol] = it.weight_value;
      end
      REQ_APPEND: begin
        if (t_pos == 0 && s_cnt < S_LEN) begin
          s_sym[s_cnt] = it.symbol;
          s_cnt++;
        end
      end
      REQ_STREAM: begin
        col = t_pos;
        for (int i = 0; i < s_cnt; i++) begin
          // own score of the cell
          if (s_sym[i] != it.symbol) begin
            own = {{(SCORE_W-PEN_W){mism_pen[PEN_W-1]}}, mism_pen};
          end else if (s_sym[i] < ALPHABET) begin
            own = {{(SCORE_W-WEIGHT_W){1'b0}}, letter_wt[s_sym[i]]};
          end else begin
            own = '0;
          end
          // diagonal extension with saturation
          if (i == 0 || col == 0) begin
            new_sc[i] = own;
            new_rn[i] = 1;
          end else begin
            diag = col_sc[i-1];
            sum  = longint'(diag) + longint'(own);
            if (sum > SCORE_HI) sum = SCORE_HI;
            else if (sum < SCORE_LO) sum = SCORE_LO;
            ext = sum[SCORE_W-1:0];
            new_sc[i] = (ext > own) ? ext : own;
            new_rn[i] = (diag >= 0) ? col_rn[i-1] + 1 : 1;
          end
          // best cell, lowest row then lowest column wins ties
          v = new_sc[i];
          if (!have_best) take = (v > min_score);
          else take = (v > best_val) || (v == best_val && i < best_r);
          if (take) begin
            best_val  = v;
            best_r    = i;
            best_c    = col;
            best_rn   = new_rn[i];
            have_best = 1'b1;
          end
        end
        for (int i = 0; i < s_cnt; i++) begin
          col_sc[i] = new_sc[i];
          col_rn[i] = new_rn[i];
        end
        if (t_pos < TPOS_MAX) t_pos++;
        if (it.is_last) begin
          rpt = '0;
          if (have_best) begin
            rpt.top_score    = best_val;
            rpt.s_start      = S_IDX_W'(best_r + 1 - best_rn);
            rpt.t_start      = TPOS_W'(best_c + 1 - best_rn);
            rpt.match_length = RUN_W'(best_rn);
            rpt.found        = 1'b1;
          end
          report_q.push_back(rpt);
          drop_job();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void push_req(logic [1:0] rt, int sym, int wv, bit last);
    wcs_in_t it;
    it.req_type     = rt;
    it.symbol       = SYM_W'(sym);
    it.weight_value = WEIGHT_W'(wv);
    it.is_last      = last;
    req_q.push_back(it);
    n_items++;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) score_request(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          in_data  <= req_q.pop_front();
          in_valid <= 1'b1;
          send_gap = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor with random and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          if (n_bad < 10) $display("unexpected report: score %0d", out_data.top_score);
          n_bad++;
        end else begin
          want = report_q.pop_front();
          if (out_data.top_score !== want.top_score || out_data.s_start !== want.s_start ||
              out_data.t_start !== want.t_start ||
              out_data.match_length !== want.match_length || out_data.found !== want.found)
          begin
            if (n_bad < 10) begin
              $display("report mismatch, expected: score %0d s %0d t %0d len %0d found %0d",
                       want.top_score, want.s_start, want.t_start, want.match_length,
                       want.found);
              $display("                 actual:   score %0d s %0d t %0d len %0d found %0d",
                       out_data.top_score, out_data.s_start, out_data.t_start,
                       out_data.match_length, out_data.found);
            end
            n_bad++;
          end
        end
        n_reports++;
        recv_hold = (n_reports == LONG_HOLD_AT) ? LONG_HOLD_CYCLES : draw_wait();
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold > 0);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register write, setup then access, model updated at the write edge
  task automatic write_reg(logic sel, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (sel)
      REG_PENALTY: mism_pen = val[PEN_W-1:0];
      REG_FLOOR: begin
        min_score = val;
        if (!have_best) best_val = min_score;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // everything sent, every report back, then let a long column finish
  task automatic wait_idle();
    do @(negedge clk); while (req_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // one job: weights, S letters, T letters, with some noise beats
  task automatic gen_job(bit close_it);
    int n_s, n_t, base, span, pick, wv;
    pick = $urandom_range(0, 39);
    if (pick == 0) n_s = 0;
    else if (pick == 1) n_s = $urandom_range(56, 66);
    else n_s = $urandom_range(1, 8);
    n_t  = (n_s > 20) ? $urandom_range(1, 4) : $urandom_range(1, 12);
    base = $urandom_range(0, 28);
    span = $urandom_range(1, 3);
    repeat ($urandom_range(0, 2)) begin
      pick = $urandom_range(0, 3);
      if (pick == 0) wv = 0;
      else if (pick == 1) wv = 32767;
      else if (pick == 2) wv = $urandom_range(0, 32767);
      else wv = $urandom_range(1, 16) * 128;
      push_req(REQ_WEIGHT, base + $urandom_range(0, span), wv, 1'($urandom_range(0, 1)));
    end
    repeat (n_s)
      push_req(REQ_APPEND, base + $urandom_range(0, span), $urandom_range(0, 32767),
               1'($urandom_range(0, 1)));
    repeat (n_t - 1) begin
      if ($urandom_range(0, 9) == 0)
        push_req(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 32767),
                 1'($urandom_range(0, 1)));
      push_req(REQ_STREAM, base + $urandom_range(0, span), $urandom_range(0, 32767), 1'b0);
    end
    if (close_it)
      push_req(REQ_STREAM, base + $urandom_range(0, span), $urandom_range(0, 32767), 1'b1);
  endtask

  initial begin : stim
    int k, goal, pick;
    logic [DATA_W-1:0] pen_v, floor_v;
    mism_pen  = PENALTY_RST;
    min_score = FLOOR_RST;
    for (int i = 0; i < ALPHABET; i++) letter_wt[i] = '0;
    drop_job();
    quiet = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty S still reports, nothing found
    push_req(REQ_STREAM, 0, 0, 1'b1);
    // weight extremes, out-of-alphabet write dropped, stray last flags and unused code
    push_req(REQ_WEIGHT, 0, 32767, 1'b1);
    push_req(REQ_WEIGHT, 25, 0, 1'b0);
    push_req(REQ_WEIGHT, 31, 32767, 1'b0);
    push_req(REQ_WEIGHT, 1, 256, 1'b0);
    push_req(REQ_UNUSED, 3, 100, 1'b1);
    // S = A B A <31> Z, letter outside the alphabet still compares
    push_req(REQ_APPEND, 0, 0, 1'b0);
    push_req(REQ_APPEND, 1, 0, 1'b1);
    push_req(REQ_APPEND, 0, 32767, 1'b0);
    push_req(REQ_APPEND, 31, 0, 1'b0);
    push_req(REQ_APPEND, 25, 0, 1'b0);
    // T letters, an S letter mid-job is dropped
    push_req(REQ_STREAM, 0, 0, 1'b0);
    push_req(REQ_STREAM, 1, 0, 1'b0);
    push_req(REQ_APPEND, 2, 0, 1'b0);
    push_req(REQ_STREAM, 31, 0, 1'b0);
    push_req(REQ_STREAM, 0, 0, 1'b0);
    push_req(REQ_STREAM, 25, 0, 1'b1);
    // ties over rows and columns
    push_req(REQ_APPEND, 1, 0, 1'b0);
    push_req(REQ_APPEND, 1, 0, 1'b0);
    push_req(REQ_STREAM, 1, 0, 1'b0);
    push_req(REQ_STREAM, 1, 0, 1'b0);
    push_req(REQ_STREAM, 1, 0, 1'b1);
    wait_idle();

    // S overflow under the harshest penalty
    write_reg(REG_PENALTY, 32'hFFFF_8000);
    for (int i = 0; i < S_LEN + 2; i++) push_req(REQ_APPEND, i % 4, 0, 1'b0);
    for (int i = 0; i < 4; i++) push_req(REQ_STREAM, i, 0, i == 3);
    wait_idle();

    // floor lowered while a job is open and nothing has been taken
    write_reg(REG_FLOOR, 32'h7FFF_FFFF);
    push_req(REQ_APPEND, 2, 0, 1'b0);
    push_req(REQ_APPEND, 3, 0, 1'b0);
    push_req(REQ_APPEND, 2, 0, 1'b0);
    push_req(REQ_STREAM, 2, 0, 1'b0);
    push_req(REQ_STREAM, 3, 0, 1'b0);
    wait_idle();
    write_reg(REG_FLOOR, 32'h0000_0000);
    write_reg(REG_PENALTY, 32'h0000_0000);
    push_req(REQ_STREAM, 2, 0, 1'b0);
    push_req(REQ_STREAM, 2, 0, 1'b0);
    push_req(REQ_STREAM, 3, 0, 1'b1);
    wait_idle();

    // random jobs, new settings each phase, some phases leave a job open
    k = 0;
    while (n_items < ITEM_TARGET - LONG_T_LETTERS) begin
      case (k)
        0: begin pen_v = 32'hFFFF_8000; floor_v = 32'h7FFF_FFFF; end
        1: begin pen_v = 32'h0000_0000; floor_v = 32'h8000_0000; end
        2: begin pen_v = 32'hFFFF_F600; floor_v = 32'h0000_0000; end
        default: begin
          pick = $urandom_range(0, 3);
          if (pick == 0) pen_v = 32'hFFFF_8000;
          else if (pick == 1) pen_v = '0;
          else pen_v = -$urandom_range(0, 32768);
          pick = $urandom_range(0, 4);
          if (pick == 0) floor_v = 32'h8000_0000;
          else if (pick == 1) floor_v = 32'h7FFF_FFFF;
          else if (pick == 2) floor_v = $urandom;
          else floor_v = $urandom_range(0, 20000) - 5000;
        end
      endcase
      write_reg(REG_PENALTY, pen_v);
      write_reg(REG_FLOOR, floor_v);
      quiet = ($urandom_range(0, 3) == 0);
      goal = n_items + $urandom_range(60, 200);
      while (n_items < goal) gen_job(1'b1);
      if ($urandom_range(0, 2) == 0) gen_job(1'b0);
      wait_idle();
      k++;
    end

    // long T: many columns in one job, best cell found at the very end
    quiet = 1'b1;
    write_reg(REG_PENALTY, 32'hFFFF_FF00);
    write_reg(REG_FLOOR, 32'h8000_0000);
    push_req(REQ_STREAM, 0, 0, 1'b1);
    push_req(REQ_WEIGHT, 0, 1000, 1'b0);
    push_req(REQ_WEIGHT, 1, 2000, 1'b0);
    push_req(REQ_APPEND, 0, 0, 1'b0);
    push_req(REQ_APPEND, 1, 0, 1'b0);
    repeat (LONG_T_LETTERS) push_req(REQ_STREAM, $urandom_range(2, 9), 0, 1'b0);
    push_req(REQ_STREAM, 0, 0, 1'b0);
    push_req(REQ_STREAM, 1, 0, 1'b1);
    wait_idle();

    if (n_bad == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
